[rtl/slc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slc_pkg: shared types and constants for the slab layout chooser
// Field widths, controller state codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package slc_pkg;

	localparam int CHUNK_W  = 21;
	localparam int PAGE_W   = 17;
	localparam int PCNT_W   = 9;
	localparam int CCNT_W   = 25;
	localparam int SLAB_W   = 25;
	localparam int TOTAL_W  = 23;
	localparam int NPG_W    = 7;
	localparam int DIV_STEPS = 25;
	localparam int DCNT_W   = 5;

	localparam logic [NPG_W-1:0] PAGES_SMALL = 7'd16;
	localparam logic [NPG_W-1:0] PAGES_LARGE = 7'd64;
	localparam logic [PAGE_W-1:0] PG_BYTES_RST = 17'd4096;

	// APB register index (paddr[2])
	localparam logic REG_PG_BYTES = 1'b0;

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b000000000001,
		ST_CSTART = 12'b000000000010,
		ST_CWAIT  = 12'b000000000100,
		ST_EVAL   = 12'b000000001000,
		ST_PICK   = 12'b000000010000,
		ST_MULC   = 12'b000000100000,
		ST_PSTART = 12'b000001000000,
		ST_PWAIT  = 12'b000010000000,
		ST_SCALE  = 12'b000100000000,
		ST_MULF   = 12'b001000000000,
		ST_FSTART = 12'b010000000000,
		ST_FWAIT  = 12'b100000000000
	} slc_state_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_slab;
		logic eval;
		logic pick;
		logic mul_chosen;
		logic scale;
		logic mul_fin;
		logic emit;
	} slc_cmd_t;

	typedef struct packed {
		logic div_done;
		logic last_cand;
	} slc_status_t;

endpackage
`default_nettype wire

[rtl/slc_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slc_div: radix-2 restoring divider
// 25-bit dividend by 21-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module slc_div import slc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [SLAB_W-1:0]  dividend,
	input  wire logic [CHUNK_W-1:0] divisor,
	output logic                    done,
	output logic [SLAB_W-1:0]       quotient,
	output logic [CHUNK_W-1:0]      remainder
);

	logic [CHUNK_W-1:0] rem_q;
	logic [SLAB_W-1:0]  quo_q;
	logic [DCNT_W-1:0]  cnt_q;
	logic               run_q;
	logic               done_q;
	logic [CHUNK_W:0]   trial;
	logic [CHUNK_W:0]   diff;
	logic               ge;

	assign trial = {rem_q, quo_q[SLAB_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? diff[CHUNK_W-1:0] : trial[CHUNK_W-1:0];
			quo_q <= {quo_q[SLAB_W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

[rtl/slc_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slc_dp: slab layout datapath
// Candidate sweep, best-waste tracking, scaling and final slab division.
// ----------------------------------------------------------------------------
module slc_dp import slc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire slc_cmd_t           cmd,
	output slc_status_t             status,
	input  wire logic [CHUNK_W-1:0] obj_size,
	input  wire logic [PAGE_W-1:0]  pg_bytes,
	output logic                    done,
	output logic [PCNT_W-1:0]       slab_pages,
	output logic [CHUNK_W-1:0]      obj_size_out,
	output logic [CCNT_W-1:0]       obj_count,
	output logic [CCNT_W-1:0]       slack_bytes
);

	logic [CHUNK_W-1:0] chunk_q;
	logic [NPG_W-1:0]   limit_q;
	logic [NPG_W-1:0]   n_q;
	logic [TOTAL_W-1:0] total_q;
	logic               found_q;
	logic [NPG_W-1:0]   good_pages_q;
	logic [CHUNK_W-1:0] good_waste_q;
	logic [NPG_W-1:0]   fb_pages_q;
	logic [CHUNK_W-1:0] fb_waste_q;
	logic [NPG_W-1:0]   chosen_q;
	logic [SLAB_W-1:0]  slab_q;
	logic [PCNT_W-1:0]  fin_q;
	logic               src_slab_q;
	logic               done_q;
	logic [PCNT_W-1:0]  slab_pages_q;
	logic [CHUNK_W-1:0] chunk_out_q;
	logic [CCNT_W-1:0]  obj_count_q;
	logic [CCNT_W-1:0]  wasted_q;

	logic [SLAB_W-1:0]  dvd_in;
	logic [SLAB_W-1:0]  dvd_cur;
	logic               div_done;
	logic [SLAB_W-1:0]  div_quo;
	logic [CHUNK_W-1:0] div_rem;
	logic               zero_div;
	logic [SLAB_W-1:0]  quo;
	logic [SLAB_W-1:0]  rem;
	logic [CHUNK_W-1:0] w;
	logic [SLAB_W-1:0]  w10;
	logic               qual;
	logic               hit;
	logic [31:0]        w80;
	logic               low_waste;
	logic [9:0]         scaled;
	logic [9:0]         cap;
	logic [23:0]        prod_c;
	logic [25:0]        prod_f;

	assign dvd_in  = cmd.div_slab ? slab_q : {2'b0, total_q};
	assign dvd_cur = src_slab_q ? slab_q : {2'b0, total_q};

	slc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd_in),
		.divisor  (chunk_q),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// a zero chunk divides to quotient 0, remainder = dividend
	assign zero_div = chunk_q == '0;
	assign quo      = zero_div ? '0 : div_quo;
	assign rem      = zero_div ? dvd_cur : {4'b0, div_rem};

	assign w    = rem[CHUNK_W-1:0];
	assign w10  = ({4'b0, w} << 3) + ({4'b0, w} << 1);
	assign qual = w10 <= {2'b0, total_q};
	assign hit  = quo != '0;

	assign w80       = ({7'b0, rem} << 6) + ({7'b0, rem} << 4);
	assign low_waste = w80 <= {7'b0, slab_q};
	assign cap       = {1'b0, limit_q, 2'b0};

	always_comb begin
		if (rem == '0)
			scaled = {chosen_q, 3'b0};
		else if (low_waste)
			scaled = {1'b0, chosen_q, 2'b0};
		else
			scaled = {3'b0, chosen_q};
	end

	assign prod_c = {17'b0, chosen_q} * {7'b0, pg_bytes};
	assign prod_f = {17'b0, fin_q} * {9'b0, pg_bytes};

	always_ff @(posedge clk) begin
		if (cmd.div_start)
			src_slab_q <= cmd.div_slab;
		if (cmd.load) begin
			chunk_q    <= obj_size;
			limit_q    <= (obj_size >= {7'b0, pg_bytes[PAGE_W-1:3]}) ?
				PAGES_LARGE : PAGES_SMALL;
			n_q        <= NPG_W'(1);
			total_q    <= {6'b0, pg_bytes};
			found_q    <= 1'b0;
			fb_pages_q <= NPG_W'(1);
			fb_waste_q <= {4'b0, pg_bytes};
		end
		if (cmd.eval) begin
			if (hit) begin
				if (qual) begin
					found_q <= 1'b1;
					if (!found_q || w < good_waste_q) begin
						good_waste_q <= w;
						good_pages_q <= n_q;
					end
				end
				if (w < fb_waste_q) begin
					fb_waste_q <= w;
					fb_pages_q <= n_q;
				end
			end
			n_q     <= n_q + 1'b1;
			total_q <= total_q + {6'b0, pg_bytes};
		end
		if (cmd.pick)
			chosen_q <= found_q ? good_pages_q : fb_pages_q;
		if (cmd.mul_chosen)
			slab_q <= {1'b0, prod_c};
		if (cmd.scale)
			fin_q <= (scaled > cap) ? cap[PCNT_W-1:0] : scaled[PCNT_W-1:0];
		if (cmd.mul_fin)
			slab_q <= prod_f[SLAB_W-1:0];
		if (cmd.emit) begin
			slab_pages_q <= fin_q;
			chunk_out_q  <= chunk_q;
			obj_count_q  <= quo;
			wasted_q     <= rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= cmd.emit;
	end

	assign status.div_done  = div_done;
	assign status.last_cand = n_q == limit_q;

	assign done         = done_q;
	assign slab_pages   = slab_pages_q;
	assign obj_size_out = chunk_out_q;
	assign obj_count    = obj_count_q;
	assign slack_bytes  = wasted_q;

endmodule
`default_nettype wire

[rtl/slc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slc_ctrl: slab layout controller
// Sequences the candidate sweep, the chosen-count division and the final one.
// ----------------------------------------------------------------------------
module slc_ctrl import slc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	output slc_cmd_t         cmd,
	input  wire slc_status_t status
);

	slc_state_t state_q;
	slc_state_t state_nx;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nx = ST_CSTART;
				end
			end
			ST_CSTART: begin
				cmd.div_start = 1'b1;
				state_nx      = ST_CWAIT;
			end
			ST_CWAIT: begin
				if (status.div_done)
					state_nx = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_nx = status.last_cand ? ST_PICK : ST_CSTART;
			end
			ST_PICK: begin
				cmd.pick = 1'b1;
				state_nx = ST_MULC;
			end
			ST_MULC: begin
				cmd.mul_chosen = 1'b1;
				state_nx       = ST_PSTART;
			end
			ST_PSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_slab  = 1'b1;
				state_nx      = ST_PWAIT;
			end
			ST_PWAIT: begin
				if (status.div_done)
					state_nx = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_nx  = ST_MULF;
			end
			ST_MULF: begin
				cmd.mul_fin = 1'b1;
				state_nx    = ST_FSTART;
			end
			ST_FSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_slab  = 1'b1;
				state_nx      = ST_FWAIT;
			end
			ST_FWAIT: begin
				if (status.div_done) begin
					cmd.emit = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	assign busy = state_q != ST_IDLE;

endmodule
`default_nettype wire

[rtl/slab_layout_chooser_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slab_layout_chooser_unit: picks slab size in pages for a chunk size
//
// channel   | handshake                     | payload
// ----------+-------------------------------+----------------------------------
// request   | start & !busy                 | obj_size
// result    | done (one-cycle strobe)       | slab_pages, obj_size_out,
//           |                               | obj_count, slack_bytes
// config    | psel & penable & pwrite       | paddr, pwdata (pg_bytes @ 0x0)
//
// One request at a time; busy falls at the edge that raises its result strobe.
// Each division on the shared radix-2 divider runs 25 steps. One candidate is
// a divider issue, the wait for its done and an evaluation; a request sweeps
// L candidates, where L is the page limit (16 or 64), then divides twice more
// and can be followed by the next accept as soon as its result is strobed.
// Reset clears the controller and sets pg_bytes to 4096.
// Results are strobed for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module slab_layout_chooser_unit import slc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [CHUNK_W-1:0] obj_size,
	output logic                    done,
	output logic [PCNT_W-1:0]       slab_pages,
	output logic [CHUNK_W-1:0]      obj_size_out,
	output logic [CCNT_W-1:0]       obj_count,
	output logic [CCNT_W-1:0]       slack_bytes,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	logic [PAGE_W-1:0] pg_bytes_q;
	slc_cmd_t          cmd;
	slc_status_t       status;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pg_bytes_q <= PG_BYTES_RST;
		else if (psel && penable && pwrite && pready && paddr[2] == REG_PG_BYTES)
			pg_bytes_q <= pwdata[PAGE_W-1:0];
	end

	assign prdata = (paddr[2] == REG_PG_BYTES) ? {15'b0, pg_bytes_q} : '0;

	slc_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.status(status)
	);

	slc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.obj_size    (obj_size),
		.pg_bytes    (pg_bytes_q),
		.done        (done),
		.slab_pages  (slab_pages),
		.obj_size_out(obj_size_out),
		.obj_count   (obj_count),
		.slack_bytes (slack_bytes)
	);

endmodule
`default_nettype wire

[bench/slab_layout_chooser_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_layout_chooser_unit_tb: self-checking bench for the slab layout chooser
// Page size is written over APB, then chunk-size requests are issued. Each
// result is checked field by field against an in-bench layout predictor
// (or a hand-computed value for the obvious directed rows). Idle gaps vary
// by phase, and page sizes run from zero to the full register width.
// ----------------------------------------------------------------------------
module slab_layout_chooser_unit_tb;
	import slc_pkg::*;

	typedef struct packed {
		logic [PCNT_W-1:0]  pages;
		logic [CHUNK_W-1:0] chunk;
		logic [CCNT_W-1:0]  chunks;
		logic [CCNT_W-1:0]  waste;
	} layout_t;

	typedef struct packed {
		logic [PAGE_W-1:0]  pg;
		logic [CHUNK_W-1:0] chunk;
		logic               typed;
		layout_t            want;
	} layout_row_t;

	localparam int NUM_ROWS = 25;
	localparam layout_t NO_LAYOUT = '0;

	// rows with typed = 1 carry a hand-computed layout
	localparam layout_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
		'{17'd4096,   21'd4096,     1'b1, '{9'd8,  21'd4096,     25'd8,     25'd0}},
		'{17'd4096,   21'd0,        1'b1, '{9'd1,  21'd0,        25'd0,     25'd4096}},
		'{17'd4096,   21'd1,        1'b1, '{9'd8,  21'd1,        25'd32768, 25'd0}},
		'{17'd4096,   21'h1FFFFF,   1'b1, '{9'd1,  21'h1FFFFF,   25'd0,     25'd4096}},
		'{17'd4096,   21'd8192,     1'b1, '{9'd16, 21'd8192,     25'd8,     25'd0}},
		'{17'd4096,   21'd511,      1'b0, NO_LAYOUT},
		'{17'd4096,   21'd512,      1'b0, NO_LAYOUT},
		'{17'd4096,   21'd3000,     1'b0, NO_LAYOUT},
		'{17'd4096,   21'd4000,     1'b0, NO_LAYOUT},
		'{17'd4096,   21'd1048576,  1'b0, NO_LAYOUT},
		'{17'd4096,   21'h155555,   1'b0, NO_LAYOUT},
		'{17'd4096,   21'h0AAAAA,   1'b0, NO_LAYOUT},
		'{17'd256,    21'd256,      1'b1, '{9'd8,  21'd256,      25'd8,     25'd0}},
		'{17'd256,    21'd9472,     1'b0, NO_LAYOUT},
		'{17'd256,    21'd31,       1'b0, NO_LAYOUT},
		'{17'd256,    21'd33,       1'b0, NO_LAYOUT},
		'{17'd65536,  21'd65536,    1'b1, '{9'd8,  21'd65536,    25'd8,     25'd0}},
		'{17'd65536,  21'd1000,     1'b0, NO_LAYOUT},
		'{17'd65536,  21'd1048576,  1'b0, NO_LAYOUT},
		'{17'd131071, 21'd131071,   1'b1, '{9'd8,  21'd131071,   25'd8,     25'd0}},
		'{17'd131071, 21'h1FFFFF,   1'b0, NO_LAYOUT},
		'{17'd0,      21'd12345,    1'b1, '{9'd8,  21'd12345,    25'd0,     25'd0}},
		'{17'd0,      21'd0,        1'b1, '{9'd8,  21'd0,        25'd0,     25'd0}},
		'{17'd4001,   21'd77,       1'b0, NO_LAYOUT},
		'{17'd4001,   21'd500,      1'b0, NO_LAYOUT}
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [CHUNK_W-1:0] obj_size;
	logic               done;
	logic [PCNT_W-1:0]  slab_pages;
	logic [CHUNK_W-1:0] obj_size_out;
	logic [CCNT_W-1:0]  obj_count;
	logic [CCNT_W-1:0]  slack_bytes;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	logic [PAGE_W-1:0]  page_cfg;
	layout_t            pending_layouts[$];
	int                 idle_pct;
	int                 mismatches = 0;

	slab_layout_chooser_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.obj_size       (obj_size),
		.done           (done),
		.slab_pages     (slab_pages),
		.obj_size_out   (obj_size_out),
		.obj_count      (obj_count),
		.slack_bytes    (slack_bytes),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	always #5 clk = ~clk;

	function automatic layout_t predict_layout(input logic [CHUNK_W-1:0] chunk_in,
			input logic [PAGE_W-1:0] pg_in);
		longint unsigned c, p, lim, n, tot, w;
		longint unsigned fb_n, fb_w, gd_n, gd_w, sel, slab, mult, fin;
		bit              found;
		layout_t         res;
		c = chunk_in;
		p = pg_in;
		lim = (c >= p / 8) ? 64 : 16;
		fb_n = 1;
		fb_w = p;
		gd_n = 0;
		gd_w = '1;
		found = 0;
		for (n = 1; n <= lim; n++) begin
			tot = n * p;
			// candidate must hold at least one chunk
			if (c == 0 || tot < c)
				continue;
			w = tot % c;
			if (w == 0 || tot / 10 >= w) begin
				found = 1;
				if (w < gd_w) begin
					gd_w = w;
					gd_n = n;
				end
			end
			if (w < fb_w) begin
				fb_w = w;
				fb_n = n;
			end
		end
		sel = found ? gd_n : fb_n;
		slab = sel * p;
		w = (c != 0) ? slab % c : slab;
		mult = 1;
		if (w == 0)
			mult = 8;
		else if (w <= slab / 80)
			mult = 4;
		fin = sel * mult;
		if (fin > lim * 4)
			fin = lim * 4;
		slab = fin * p;
		res.pages  = fin[PCNT_W-1:0];
		res.chunk  = chunk_in;
		res.chunks = (c != 0) ? CCNT_W'(slab / c) : '0;
		res.waste  = (c != 0) ? CCNT_W'(slab % c) : CCNT_W'(slab);
		return res;
	endfunction

	function automatic logic [CHUNK_W-1:0] pick_chunk(input logic [PAGE_W-1:0] pg_in);
		int unsigned sel, hi, v;
		sel = $urandom_range(99, 0);
		if (sel < 40) begin
			// up to pg/8 + 1: short page limit, plus the edge into the long one
			v = $urandom_range(pg_in / 8 + 1, 1);
		end else if (sel < 70) begin
			hi = 4 * pg_in + 1;
			if (hi > 1048576)
				hi = 1048576;
			v = $urandom_range(hi, 1);
		end else if (sel < 85) begin
			// near divisors of a few pages
			v = (pg_in * $urandom_range(8, 1)) / $urandom_range(16, 1) + $urandom_range(2, 0);
		end else if (sel < 95) begin
			v = $urandom_range(1048576, 1);
		end else begin
			v = $urandom;
		end
		return v[CHUNK_W-1:0];
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch @%0t: %s", $realtime, what);
		mismatches++;
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic issue_request(input logic [CHUNK_W-1:0] chunk, input layout_t want);
		while ($urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		obj_size <= chunk;
		do
			@(posedge clk);
		while (busy);
		pending_layouts.push_back(want);
		@(negedge clk);
	endtask

	task automatic write_page_cfg(input logic [PAGE_W-1:0] value);
		start <= 1'b0;
		while (pending_layouts.size() != 0 || busy)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_PG_BYTES, 2'b00};
		pwdata  <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		page_cfg = value;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	always @(posedge clk) begin : result_check
		layout_t want;
		if (arst_n && done) begin
			if (pending_layouts.size() == 0) begin
				report_mismatch("result with no request pending");
			end else begin
				want = pending_layouts.pop_front();
				if (slab_pages !== want.pages)
					report_mismatch($sformatf("chunk %0d: slab_pages %0d, want %0d",
						want.chunk, slab_pages, want.pages));
				if (obj_size_out !== want.chunk)
					report_mismatch($sformatf("obj_size_out %0d, want %0d",
						obj_size_out, want.chunk));
				if (obj_count !== want.chunks)
					report_mismatch($sformatf("chunk %0d: obj_count %0d, want %0d",
						want.chunk, obj_count, want.chunks));
				if (slack_bytes !== want.waste)
					report_mismatch($sformatf("chunk %0d: slack_bytes %0d, want %0d",
						want.chunk, slack_bytes, want.waste));
			end
		end
	end

	initial begin
		layout_row_t       row;
		logic [PAGE_W-1:0] pg;
		logic [CHUNK_W-1:0] chunk;
		arst_n     = 1'b0;
		start      = 1'b0;
		obj_size   = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		page_cfg   = PG_BYTES_RST;
		idle_pct   = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: first rows run on the reset page size
		for (int i = 0; i < NUM_ROWS; i++) begin
			row = DIRECTED_ROWS[i];
			if (row.pg != page_cfg)
				write_page_cfg(row.pg);
			issue_request(row.chunk, row.typed ? row.want : predict_layout(row.chunk, page_cfg));
		end

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: pg = 17'd4096;
				1: pg = 17'd256;
				2: pg = PAGE_W'($urandom_range(65535, 257));
				3: pg = 17'd65536;
				4: pg = PAGE_W'($urandom_range(131071, 1));
				default: pg = 17'd4096;
			endcase
			idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 74 : 12;
			write_page_cfg(pg);
			for (int k = 0; k < 45; k++) begin
				chunk = pick_chunk(page_cfg);
				issue_request(chunk, predict_layout(chunk, page_cfg));
			end
		end

		start <= 1'b0;
		while (pending_layouts.size() != 0)
			@(posedge clk);
		// catch any stray strobe
		repeat (2000) @(posedge clk);
		if (mismatches == 0 && pending_layouts.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
